/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b in the same cycle, off during reset
`define RSQ_ASSERT_IMPL(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("rsq: implication failed");

// a implies b at the next edge, off during reset
`define RSQ_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("rsq: next-cycle check failed");

// b holds at the edge after reset is seen
`define RSQ_ASSERT_AFTER_RESET(label, clk, rst, b) \
  label: assert property (@(posedge clk) (rst) |=> (b)) else $error("rsq: reset check failed");

`endif

/* hw/rtl/rsq_pkg.sv */
`default_nettype none
package rsq_pkg;

  localparam int COORD_BITS = 32;
  localparam int ANGLE_BITS = 16;
  localparam int SIZE_BITS  = 24;
  localparam int RATIO_BITS = 16;
  localparam int FRAC_BITS  = 31;
  localparam int ACC_BITS   = 32;
  localparam int HALF_BITS  = 32;
  localparam int TRIG_BITS  = 17;
  localparam int PROD_BITS  = HALF_BITS + TRIG_BITS;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int RND_BITS   = SUM_BITS - 15;
  localparam int SAT_BITS   = ((COORD_BITS > RND_BITS) ? COORD_BITS : RND_BITS) + 2;

  localparam logic [ACC_BITS-1:0]  SIN_A   = 32'd1686629713;
  localparam logic [ACC_BITS-1:0]  SIN_B   = 32'd688904866;
  localparam logic [ACC_BITS-1:0]  SIN_C   = 32'd76016977;
  localparam logic [FRAC_BITS-1:0] ONE_Q30 = 31'd1073741824;
  localparam logic [RATIO_BITS-1:0] ASPECT_RESET = 16'd4096;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic signed [SIZE_BITS-1:0]  half_size;
    logic [ANGLE_BITS-1:0]        angle;
    logic [RATIO_BITS-1:0]        stretch_factor;
  } sprite_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] corner0_x;
    logic signed [COORD_BITS-1:0] corner0_y;
    logic signed [COORD_BITS-1:0] corner1_x;
    logic signed [COORD_BITS-1:0] corner1_y;
    logic signed [COORD_BITS-1:0] corner2_x;
    logic signed [COORD_BITS-1:0] corner2_y;
    logic signed [COORD_BITS-1:0] corner3_x;
    logic signed [COORD_BITS-1:0] corner3_y;
  } quad_t;

  typedef struct packed {
    logic [ACC_BITS-1:0]  acc;
    logic [FRAC_BITS-1:0] x2;
    logic [FRAC_BITS-1:0] f;
    logic [1:0]           quad;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] cx;
    logic signed [COORD_BITS-1:0] cy;
    logic signed [HALF_BITS-1:0]  hw;
    logic signed [HALF_BITS-1:0]  hh;
  } ctx_t;

endpackage
`default_nettype wire

/* hw/rtl/rsq_horner_cell.sv */
`default_nettype none
module rsq_horner_cell #(
  parameter logic [31:0] K = rsq_pkg::SIN_B
) (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire rsq_pkg::lane_t lane_in,
  output rsq_pkg::lane_t      lane_out
);
  import rsq_pkg::*;

  logic [2*ACC_BITS-1:0] prod;
  lane_t                 lane_out_next;

  assign prod = (2*ACC_BITS)'(lane_in.acc) * (2*ACC_BITS)'(lane_in.x2);

  always_comb begin
    lane_out_next     = lane_in;
    lane_out_next.acc = K - prod[ACC_BITS+29:30];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lane_out <= lane_out_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rsq_coord_cell.sv */
`default_nettype none
module rsq_coord_cell #(
  parameter bit NEG_P = 1'b0,
  parameter bit NEG_Q = 1'b0
) (
  input  wire logic                                 clk,
  input  wire logic                                 en,
  input  wire logic signed [rsq_pkg::PROD_BITS-1:0] p,
  input  wire logic signed [rsq_pkg::PROD_BITS-1:0] q,
  input  wire logic signed [rsq_pkg::COORD_BITS-1:0] center,
  output logic signed [rsq_pkg::COORD_BITS-1:0]      coord
);
  import rsq_pkg::*;

  localparam logic signed [SAT_BITS-1:0] HI = SAT_BITS'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [SAT_BITS-1:0] LO = -HI - SAT_BITS'(1);

  logic signed [SUM_BITS-1:0]   tp, tq, sum, biased;
  logic signed [RND_BITS-1:0]   rnd;
  logic signed [RND_BITS-1:0]   rnd_r;
  logic signed [COORD_BITS-1:0] center_r;
  logic signed [SAT_BITS-1:0]   total;
  logic signed [COORD_BITS-1:0] coord_next;

  always_comb begin
    tp     = NEG_P ? -SUM_BITS'(p) : SUM_BITS'(p);
    tq     = NEG_Q ? -SUM_BITS'(q) : SUM_BITS'(q);
    sum    = tp + tq;
    biased = sum + SUM_BITS'(16384);
    rnd    = RND_BITS'(biased >>> 15);
  end

  always_comb begin
    total = SAT_BITS'(rnd_r) + SAT_BITS'(center_r);
    if (total > HI) begin
      coord_next = COORD_BITS'(HI);
    end else if (total < LO) begin
      coord_next = COORD_BITS'(LO);
    end else begin
      coord_next = COORD_BITS'(total);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r    <= rnd;
      center_r <= center;
      coord    <= coord_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rotated_sprite_quad_expander.sv */
// Pipeline: each accepted sprite word passes through the stages below to its quad word.
// Throughput: one sprite word per cycle; the whole pipeline holds while a
// finished quad word is stalled at the output register.
// Reset: rst clears the valid bits of all stages and sets the aspect
// register to 16.0; payload registers are not reset.
`default_nettype none
module rotated_sprite_quad_expander (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               sprite_valid,
  output logic                                    sprite_stall,
  input  wire rsq_pkg::sprite_t                   sprite,
  output logic                                    quad_valid,
  input  wire logic                               quad_stall,
  output rsq_pkg::quad_t                          quad,
  input  wire logic                               cfg_we,
  input  wire logic [rsq_pkg::RATIO_BITS-1:0]     cfg_wdata
);
  import rsq_pkg::*;

  localparam int STAGES = 9;

  logic [RATIO_BITS-1:0] inverse_aspect;
  logic [STAGES-1:0]     valid;
  logic                  adv;

  ctx_t  ctx [0:6];
  ctx_t  ctx_in;
  lane_t lane0_s, lane0_c, lane1_s, lane1_c, lane2_s, lane2_c, lane3_s, lane3_c;
  lane_t lane_in_s, lane_in_c;

  logic [ACC_BITS-1:0]          s4_s, s4_c;
  logic [1:0]                   q4_s, q4_c;
  logic                         z4;
  logic signed [TRIG_BITS-1:0]  sn, cs;
  logic signed [PROD_BITS-1:0]  pa, pb, pc, pd;

  assign adv          = !quad_stall || !valid[STAGES-1];
  assign sprite_stall = !adv;
  assign quad_valid   = valid[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_aspect <= ASPECT_RESET;
    end else if (cfg_we) begin
      inverse_aspect <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (adv) begin
      valid <= {valid[STAGES-2:0], sprite_valid};
    end
  end

  // stage 0: clamp size, half extents, quarter and in-quarter phase
  logic [SIZE_BITS-2:0]            hsc;
  logic [SIZE_BITS+RATIO_BITS-2:0] hw_full, hh_full;
  logic [31:0]                     phase;
  logic [1:0]                      qs, qc;
  logic [FRAC_BITS-1:0]            frac;

  always_comb begin
    hsc     = sprite.half_size[SIZE_BITS-1] ? (SIZE_BITS-1)'(1) : sprite.half_size[SIZE_BITS-2:0];
    hw_full = (SIZE_BITS+RATIO_BITS-1)'(hsc) * (SIZE_BITS+RATIO_BITS-1)'(inverse_aspect)
            + (SIZE_BITS+RATIO_BITS-1)'(128);
    hh_full = (SIZE_BITS+RATIO_BITS-1)'(hsc) * (SIZE_BITS+RATIO_BITS-1)'(sprite.stretch_factor)
            + (SIZE_BITS+RATIO_BITS-1)'(128);
    phase   = 32'(sprite.angle) << (32 - ANGLE_BITS);
    qs      = phase[31:30];
    qc      = qs + 2'd1;
    frac    = {1'b0, phase[29:0]};
    ctx_in.cx = sprite.center_x;
    ctx_in.cy = sprite.center_y;
    ctx_in.hw = HALF_BITS'(hw_full[SIZE_BITS+RATIO_BITS-2:8]);
    ctx_in.hh = HALF_BITS'(hh_full[SIZE_BITS+RATIO_BITS-2:8]);
    lane_in_s.acc  = '0;
    lane_in_s.x2   = '0;
    lane_in_s.f    = qs[0] ? ONE_Q30 - frac : frac;
    lane_in_s.quad = qs;
    lane_in_s.zero = (sprite.angle == '0);
    lane_in_c      = lane_in_s;
    lane_in_c.f    = qc[0] ? ONE_Q30 - frac : frac;
    lane_in_c.quad = qc;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctx[0]  <= ctx_in;
      lane0_s <= lane_in_s;
      lane0_c <= lane_in_c;
      for (int i = 1; i < 7; i++) begin
        ctx[i] <= ctx[i-1];
      end
    end
  end

  // stage 1: square of the phase
  logic [2*FRAC_BITS-1:0] sq_s, sq_c;
  lane_t                  lane1_s_next, lane1_c_next;

  assign sq_s = (2*FRAC_BITS)'(lane0_s.f) * (2*FRAC_BITS)'(lane0_s.f);
  assign sq_c = (2*FRAC_BITS)'(lane0_c.f) * (2*FRAC_BITS)'(lane0_c.f);

  always_comb begin
    lane1_s_next     = lane0_s;
    lane1_s_next.acc = SIN_C;
    lane1_s_next.x2  = sq_s[FRAC_BITS+29:30];
    lane1_c_next     = lane0_c;
    lane1_c_next.acc = SIN_C;
    lane1_c_next.x2  = sq_c[FRAC_BITS+29:30];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lane1_s <= lane1_s_next;
      lane1_c <= lane1_c_next;
    end
  end

  // stages 2 and 3: polynomial steps
  rsq_horner_cell #(.K(SIN_B)) u_hb_s (.clk(clk), .en(adv), .lane_in(lane1_s), .lane_out(lane2_s));
  rsq_horner_cell #(.K(SIN_B)) u_hb_c (.clk(clk), .en(adv), .lane_in(lane1_c), .lane_out(lane2_c));
  rsq_horner_cell #(.K(SIN_A)) u_ha_s (.clk(clk), .en(adv), .lane_in(lane2_s), .lane_out(lane3_s));
  rsq_horner_cell #(.K(SIN_A)) u_ha_c (.clk(clk), .en(adv), .lane_in(lane2_c), .lane_out(lane3_c));

  // stage 4: final multiply by the phase
  logic [2*ACC_BITS-1:0] fin_s, fin_c;

  assign fin_s = (2*ACC_BITS)'(lane3_s.acc) * (2*ACC_BITS)'(lane3_s.f);
  assign fin_c = (2*ACC_BITS)'(lane3_c.acc) * (2*ACC_BITS)'(lane3_c.f);

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_s <= fin_s[ACC_BITS+29:30];
      s4_c <= fin_c[ACC_BITS+29:30];
      q4_s <= lane3_s.quad;
      q4_c <= lane3_c.quad;
      z4   <= lane3_s.zero;
    end
  end

  // stage 5: round to Q1.15 and apply the half-turn sign
  logic [ACC_BITS:0]           r_s, r_c;
  logic signed [TRIG_BITS-1:0] sn_next, cs_next;

  always_comb begin
    r_s = ((ACC_BITS+1)'(s4_s) + (ACC_BITS+1)'(16384)) >> 15;
    r_c = ((ACC_BITS+1)'(s4_c) + (ACC_BITS+1)'(16384)) >> 15;
    sn_next = q4_s[1] ? -$signed(r_s[TRIG_BITS-1:0]) : $signed(r_s[TRIG_BITS-1:0]);
    cs_next = q4_c[1] ? -$signed(r_c[TRIG_BITS-1:0]) : $signed(r_c[TRIG_BITS-1:0]);
    if (z4) begin
      sn_next = '0;
      cs_next = TRIG_BITS'(32768);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sn <= sn_next;
      cs <= cs_next;
    end
  end

  // stage 6: rotation products
  always_ff @(posedge clk) begin
    if (adv) begin
      pa <= PROD_BITS'(ctx[5].hw) * PROD_BITS'(cs);
      pb <= PROD_BITS'(ctx[5].hh) * PROD_BITS'(sn);
      pc <= PROD_BITS'(ctx[5].hw) * PROD_BITS'(sn);
      pd <= PROD_BITS'(ctx[5].hh) * PROD_BITS'(cs);
    end
  end

  // stages 7 and 8: one cell per corner coordinate
  rsq_coord_cell #(.NEG_P(1'b1), .NEG_Q(1'b1)) u_c0x (.clk(clk), .en(adv), .p(pa), .q(pb),
    .center(ctx[6].cx), .coord(quad.corner0_x));
  rsq_coord_cell #(.NEG_P(1'b1), .NEG_Q(1'b0)) u_c0y (.clk(clk), .en(adv), .p(pc), .q(pd),
    .center(ctx[6].cy), .coord(quad.corner0_y));
  rsq_coord_cell #(.NEG_P(1'b1), .NEG_Q(1'b0)) u_c1x (.clk(clk), .en(adv), .p(pa), .q(pb),
    .center(ctx[6].cx), .coord(quad.corner1_x));
  rsq_coord_cell #(.NEG_P(1'b1), .NEG_Q(1'b1)) u_c1y (.clk(clk), .en(adv), .p(pc), .q(pd),
    .center(ctx[6].cy), .coord(quad.corner1_y));
  rsq_coord_cell #(.NEG_P(1'b0), .NEG_Q(1'b1)) u_c2x (.clk(clk), .en(adv), .p(pa), .q(pb),
    .center(ctx[6].cx), .coord(quad.corner2_x));
  rsq_coord_cell #(.NEG_P(1'b0), .NEG_Q(1'b0)) u_c2y (.clk(clk), .en(adv), .p(pc), .q(pd),
    .center(ctx[6].cy), .coord(quad.corner2_y));
  rsq_coord_cell #(.NEG_P(1'b0), .NEG_Q(1'b0)) u_c3x (.clk(clk), .en(adv), .p(pa), .q(pb),
    .center(ctx[6].cx), .coord(quad.corner3_x));
  rsq_coord_cell #(.NEG_P(1'b0), .NEG_Q(1'b1)) u_c3y (.clk(clk), .en(adv), .p(pc), .q(pd),
    .center(ctx[6].cy), .coord(quad.corner3_y));

endmodule
`default_nettype wire

/* hw/rtl/rsq_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module rsq_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           sprite_stall,
  input wire logic           quad_valid,
  input wire logic           quad_stall,
  input wire rsq_pkg::quad_t quad
);
  import rsq_pkg::*;

  `RSQ_ASSERT_NEXT(a_quad_hold, clk, rst, quad_valid && quad_stall, quad_valid && $stable(quad))
  `RSQ_ASSERT_IMPL(a_stall_cause, clk, rst, sprite_stall, quad_valid && quad_stall)
  `RSQ_ASSERT_IMPL(a_stall_pass, clk, rst, quad_valid && quad_stall, sprite_stall)
  `RSQ_ASSERT_AFTER_RESET(a_reset_empty, clk, rst, !quad_valid)

endmodule

bind rotated_sprite_quad_expander rsq_checker u_rsq_checker (
  .clk(clk),
  .rst(rst),
  .sprite_stall(sprite_stall),
  .quad_valid(quad_valid),
  .quad_stall(quad_stall),
  .quad(quad)
);
`default_nettype wire

/* tb/rotated_sprite_quad_expander_test.sv */
`timescale 1ns / 1ps
module rotated_sprite_quad_expander_test;
  import rsq_pkg::*;

  class quad_scoreboard;
    quad_t pending[$];
    int errors;
    int checked;
    logic [15:0] aspect;

    function new();
      errors = 0;
      checked = 0;
      aspect = ASPECT_RESET;
    endfunction

    function longint qsin(logic [31:0] p);
      logic [1:0] q;
      longint unsigned f, x2, t, s;
      q = p[31:30];
      f = 64'(p[29:0]);
      if (q[0]) f = 64'd1073741824 - f;
      x2 = (f * f) >> 30;
      t = 64'd688904866 - ((64'd76016977 * x2) >> 30);
      t = 64'd1686629713 - ((t * x2) >> 30);
      s = (t * f) >> 30;
      s = (s + 16384) >> 15;
      return q[1] ? -longint'(s) : longint'(s);
    endfunction

    function longint rnd15(longint v);
      return (v + 16384) >>> 15;
    endfunction

    function logic [31:0] clip(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
    endfunction

    function void note_sprite(sprite_t s);
      longint cx, cy, hs, hw, hh, sn, cs, dx, dy, vx, vy;
      logic [31:0] c[8];
      logic [31:0] p;
      quad_t r;
      cx = longint'(s.center_x);
      cy = longint'(s.center_y);
      hs = longint'(s.half_size);
      if (hs < 0) hs = 1;
      hw = (hs * longint'({1'b0, aspect}) + 128) >>> 8;
      hh = (hs * longint'({1'b0, s.stretch_factor}) + 128) >>> 8;
      p = {s.angle, 16'h0};
      sn = qsin(p);
      cs = qsin(p + 32'h40000000);
      for (int k = 0; k < 4; k++) begin
        dx = (k < 2) ? -hw : hw;
        dy = (k[0]) ? -hh : hh;
        if (s.angle == 0) begin
          vx = cx + dx;
          vy = cy + dy;
        end else begin
          vx = cx + rnd15(dx * cs - dy * sn);
          vy = cy + rnd15(dx * sn + dy * cs);
        end
        c[2*k] = clip(vx);
        c[2*k+1] = clip(vy);
      end
      r = {c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7]};
      pending = {pending, r};
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      errors++;
    endtask

    task check_quad(quad_t q);
      quad_t e;
      if (pending.size() == 0) begin
        report("unexpected quad word, corner0_x", q.corner0_x, '0);
        return;
      end
      e = pending.pop_front();
      checked++;
      if (q.corner0_x !== e.corner0_x) report("corner0_x", q.corner0_x, e.corner0_x);
      if (q.corner0_y !== e.corner0_y) report("corner0_y", q.corner0_y, e.corner0_y);
      if (q.corner1_x !== e.corner1_x) report("corner1_x", q.corner1_x, e.corner1_x);
      if (q.corner1_y !== e.corner1_y) report("corner1_y", q.corner1_y, e.corner1_y);
      if (q.corner2_x !== e.corner2_x) report("corner2_x", q.corner2_x, e.corner2_x);
      if (q.corner2_y !== e.corner2_y) report("corner2_y", q.corner2_y, e.corner2_y);
      if (q.corner3_x !== e.corner3_x) report("corner3_x", q.corner3_x, e.corner3_x);
      if (q.corner3_y !== e.corner3_y) report("corner3_y", q.corner3_y, e.corner3_y);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sprite_valid = 1'b0;
  logic sprite_stall;
  sprite_t sprite = '0;
  logic quad_valid;
  logic quad_stall = 1'b0;
  quad_t quad;
  logic cfg_we = 1'b0;
  logic [RATIO_BITS-1:0] cfg_wdata = '0;

  int send_idle = 0;
  int recv_stall = 0;
  int sent = 0;
  quad_scoreboard board;

  always #6 clk = ~clk;

  rotated_sprite_quad_expander i_dut (
    .clk(clk), .rst(rst),
    .sprite_valid(sprite_valid), .sprite_stall(sprite_stall), .sprite(sprite),
    .quad_valid(quad_valid), .quad_stall(quad_stall), .quad(quad),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    if (!rst && quad_valid && !quad_stall) board.check_quad(quad);
    if (!rst) quad_stall <= ($urandom_range(99) < recv_stall);
  end

  task automatic send_sprite(sprite_t s);
    while ($urandom_range(99) < send_idle) begin
      sprite_valid <= 1'b0;
      @(posedge clk);
    end
    sprite_valid <= 1'b1;
    sprite <= s;
    @(posedge clk);
    while (sprite_stall) @(posedge clk);
    board.note_sprite(s);
    sent++;
  endtask

  task automatic write_aspect(logic [15:0] v);
    sprite_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.aspect = v;
  endtask

  function automatic sprite_t rand_sprite();
    sprite_t s;
    s.center_x = $urandom;
    s.center_y = $urandom;
    case ($urandom_range(3))
      0: s.half_size = 24'($urandom);
      1: s.half_size = 24'($urandom_range(65536));
      2: s.half_size = -24'($urandom_range(4));
      default: s.half_size = 24'h7fffff - 24'($urandom_range(3));
    endcase
    case ($urandom_range(4))
      0: s.angle = 16'(16'h4000 * $urandom_range(3));
      1: s.angle = $urandom_range(1) ? 16'h0001 : 16'hffff;
      default: s.angle = 16'($urandom);
    endcase
    s.stretch_factor = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(8192));
    if ($urandom_range(7) == 0) s.center_x = $urandom_range(1) ? 32'h7fffff00 : 32'h80000100;
    return s;
  endfunction

  task automatic directed();
    sprite_t s;
    logic [31:0] ext[4] = '{32'h0, 32'h7fffffff, 32'h80000000, 32'h00010000};
    logic [15:0] angs[6] = '{16'h0, 16'h4000, 16'h8000, 16'hc000, 16'h1, 16'hffff};
    for (int i = 0; i < 4; i++) begin
      s.center_x = ext[i];
      s.center_y = ext[3 - i];
      s.half_size = (i == 0) ? 24'h0 : (i == 1) ? 24'h7fffff : (i == 2) ? 24'h800000 : 24'hfff;
      s.angle = angs[i];
      s.stretch_factor = (i == 1) ? 16'hffff : 16'h1000;
      send_sprite(s);
    end
    for (int i = 0; i < 6; i++) begin
      s.center_x = 32'h00100000;
      s.center_y = -32'sh00100000;
      s.half_size = 24'h004000;
      s.angle = angs[i];
      s.stretch_factor = 16'h2000;
      send_sprite(s);
    end
  endtask

  initial begin
    int phase;
    logic [15:0] aspects[5];
    aspects = '{16'h1000, 16'h0000, 16'hffff, 16'h0800, 16'h0001};
    board = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed();
    for (phase = 0; phase < 5; phase++) begin
      write_aspect(aspects[phase] ^ ((phase == 3) ? 16'($urandom) : 16'h0));
      case (phase % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 67; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 67; end
        default: begin send_idle = 11; recv_stall = 11; end
      endcase
      for (int i = 0; i < 400; i++) send_sprite(rand_sprite());
    end
    sprite_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("sent %0d sprite words, checked %0d quad words over 5 aspect settings",
             sent, board.checked);
    if (board.errors == 0) begin
      $display("rotated_sprite_quad_expander_test OK");
    end else begin
      $display("rotated_sprite_quad_expander_test NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("rotated_sprite_quad_expander_test NOT OK");
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/rsq_pkg.sv
hw/rtl/rsq_horner_cell.sv
hw/rtl/rsq_coord_cell.sv
hw/rtl/rotated_sprite_quad_expander.sv
hw/rtl/rsq_checker.sv
tb/rotated_sprite_quad_expander_test.sv
